// ===== rtl/core/vtc_pkg.sv =====
// shared types and constants for the vertex transform and clip test block
package vtc_pkg;

  // matrix shape and field widths
  localparam int MAT_DIM   = 4;
  localparam int COEF_W    = 16;
  localparam int COORD_W   = 32;
  localparam int ROW_W     = MAT_DIM * COEF_W;
  localparam int TOL_W     = 16;
  localparam int PROD_W    = COEF_W + COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int FRAC_DROP = 12;
  localparam int RND_W     = SUM_W - FRAC_DROP;
  localparam int W_SHIFT   = 16;

  // fixed-point constants
  localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(2048);
  localparam logic [COORD_W-1:0] SAT_POS    = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG    = 32'h8000_0000;
  localparam int                 LIM_W      = COORD_W + 2;
  localparam logic [LIM_W-1:0]   ONE_Q16    = LIM_W'(65536);

  // register map, index is paddr / 8
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ROW0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOL  = 3'd4;

  // one transformed point on its way to the clip test
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic [COORD_W-1:0] cw;
    logic               sat;
    logic               last;
  } vtc_entry_t;

  // queue handshake seen by the back end
  typedef struct packed {
    logic       empty;
    vtc_entry_t head;
  } vtc_qstat_t;

endpackage

// ===== rtl/core/vtc_xform.sv =====
// front end: beat intake, credit control and the pipelined 4x4 transform
module vtc_xform import vtc_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_W-1:0]       in_point_x,
  input  logic signed [COORD_W-1:0]       in_point_y,
  input  logic signed [COORD_W-1:0]       in_point_z,
  input  logic                            in_last_point,
  input  logic [MAT_DIM-1:0][ROW_W-1:0]   matrix,
  input  logic                            q_pop,
  output logic                            q_push,
  output vtc_entry_t                      q_entry
);

  localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);

  logic              accept;
  logic [CRED_W-1:0] cred_r, cred_nxt;

  logic signed [COORD_W-1:0] pt [MAT_DIM-1];

  logic                     v1_r, v2_r, v3_r;
  logic                     last1_r, last2_r;
  logic signed [PROD_W-1:0] prod_r [MAT_DIM][MAT_DIM-1];
  logic [COEF_W-1:0]        wcoef_r [MAT_DIM];
  logic [SUM_W-1:0]         pa_r [MAT_DIM];
  logic [SUM_W-1:0]         pb_r [MAT_DIM];
  logic [SUM_W-1:0]         sum  [MAT_DIM];
  logic [COORD_W-1:0]       clip [MAT_DIM];
  logic [MAT_DIM-1:0]       ovf;
  vtc_entry_t               entry_r;

  // credits cover every item between intake and queue pop
  assign accept   = in_valid && !in_stall;
  assign in_stall = (cred_r == CRED_W'(QUEUE_DEPTH));

  always_comb begin
    cred_nxt = cred_r;
    if (accept && !q_pop) begin
      cred_nxt = cred_r + CRED_W'(1);
    end else if (!accept && q_pop) begin
      cred_nxt = cred_r - CRED_W'(1);
    end
  end

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  // stage 1: coefficient by coordinate products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      cred_r <= cred_nxt;
      v1_r   <= accept;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last1_r <= in_last_point;
      for (int r = 0; r < MAT_DIM; r++) begin
        for (int c = 0; c < MAT_DIM - 1; c++) begin
          prod_r[r][c] <= $signed(matrix[r][c*COEF_W +: COEF_W]) * pt[c];
        end
        wcoef_r[r] <= matrix[r][(MAT_DIM-1)*COEF_W +: COEF_W];
      end
    end
  end

  // stage 2: pairwise partial sums, w column and rounding half folded in
  always_ff @(posedge clk) begin
    if (v1_r) begin
      last2_r <= last1_r;
      for (int r = 0; r < MAT_DIM; r++) begin
        pa_r[r] <= {{(SUM_W-PROD_W){prod_r[r][0][PROD_W-1]}}, prod_r[r][0]}
                 + {{(SUM_W-PROD_W){prod_r[r][1][PROD_W-1]}}, prod_r[r][1]};
        pb_r[r] <= {{(SUM_W-PROD_W){prod_r[r][2][PROD_W-1]}}, prod_r[r][2]}
                 + {{(SUM_W-COEF_W-W_SHIFT){wcoef_r[r][COEF_W-1]}}, wcoef_r[r],
                    {W_SHIFT{1'b0}}}
                 + ROUND_HALF;
      end
    end
  end

  // stage 3: final sum, drop to Q16.16 and saturate
  always_comb begin
    for (int r = 0; r < MAT_DIM; r++) begin
      sum[r] = pa_r[r] + pb_r[r];
      ovf[r] = !((&sum[r][SUM_W-1:FRAC_DROP+COORD_W-1]) ||
                 !(|sum[r][SUM_W-1:FRAC_DROP+COORD_W-1]));
      if (ovf[r]) begin
        clip[r] = sum[r][SUM_W-1] ? SAT_NEG : SAT_POS;
      end else begin
        clip[r] = sum[r][FRAC_DROP +: COORD_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      entry_r.cx   <= clip[0];
      entry_r.cy   <= clip[1];
      entry_r.cz   <= clip[2];
      entry_r.cw   <= clip[3];
      entry_r.sat  <= |ovf;
      entry_r.last <= last2_r;
    end
  end

  assign q_push  = v3_r;
  assign q_entry = entry_r;

endmodule

// ===== rtl/core/vtc_queue.sv =====
// small queue between the transform front end and the clip test back end
module vtc_queue import vtc_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  vtc_entry_t push_entry,
  input  logic       pop,
  output vtc_qstat_t stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vtc_entry_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // occupancy tracking
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      end
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_entry;
    end
  end

  assign stat.empty = (cnt_r == '0);
  assign stat.head  = mem[rp_r];

endmodule

// ===== rtl/core/vtc_clip.sv =====
// back end: clip volume test, run tracking and the output register
module vtc_clip import vtc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [TOL_W-1:0]           tolerance,
  input  vtc_qstat_t                 qstat,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_W-1:0]  out_clip_x,
  output logic signed [COORD_W-1:0]  out_clip_y,
  output logic signed [COORD_W-1:0]  out_clip_z,
  output logic signed [COORD_W-1:0]  out_clip_w,
  output logic                       out_overflowed,
  output logic                       out_point_inside,
  output logic                       out_run_done,
  output logic                       out_run_all_inside
);

  logic                    out_valid_r;
  logic [COORD_W-1:0]      cx_r, cy_r, cz_r, cw_r;
  logic                    sat_r, inside_r, done_r, run_ok_r;
  logic                    all_in_r, all_in_nxt;

  logic signed [LIM_W-1:0] tol_s, hi_lim, lo_lim, wlo_lim;
  logic signed [LIM_W-1:0] xs, ys, zs, ws;
  logic                    pt_in;

  // take the head whenever the output register is free or draining
  assign q_pop = !qstat.empty && (!out_valid_r || !out_stall);

  // clip volume bounds
  assign tol_s   = $signed({{(LIM_W-TOL_W){1'b0}}, tolerance});
  assign hi_lim  = $signed(ONE_Q16) + tol_s;
  assign lo_lim  = -hi_lim;
  assign wlo_lim = $signed(ONE_Q16) - tol_s;

  assign xs = $signed({{(LIM_W-COORD_W){qstat.head.cx[COORD_W-1]}}, qstat.head.cx});
  assign ys = $signed({{(LIM_W-COORD_W){qstat.head.cy[COORD_W-1]}}, qstat.head.cy});
  assign zs = $signed({{(LIM_W-COORD_W){qstat.head.cz[COORD_W-1]}}, qstat.head.cz});
  assign ws = $signed({{(LIM_W-COORD_W){qstat.head.cw[COORD_W-1]}}, qstat.head.cw});

  assign pt_in = !qstat.head.sat
              && (xs <= hi_lim) && (xs >= lo_lim)
              && (ys <= hi_lim) && (ys >= lo_lim)
              && (zs <= hi_lim) && (zs >= -tol_s)
              && (ws <= hi_lim) && (ws >= wlo_lim);

  assign all_in_nxt = all_in_r & pt_in;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      all_in_r    <= 1'b1;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        all_in_r    <= qstat.head.last ? 1'b1 : all_in_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx_r     <= qstat.head.cx;
      cy_r     <= qstat.head.cy;
      cz_r     <= qstat.head.cz;
      cw_r     <= qstat.head.cw;
      sat_r    <= qstat.head.sat;
      inside_r <= pt_in;
      done_r   <= qstat.head.last;
      run_ok_r <= qstat.head.last & all_in_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_clip_x         = cx_r;
  assign out_clip_y         = cy_r;
  assign out_clip_z         = cz_r;
  assign out_clip_w         = cw_r;
  assign out_overflowed     = sat_r;
  assign out_point_inside   = inside_r;
  assign out_run_done       = done_r;
  assign out_run_all_inside = run_ok_r;

endmodule

// ===== rtl/core/vertex_transform_clip_test_unit.sv =====
// Vertex transform with clip test: one point per cycle sustained while out_stall is low.
// Path: product, partial sum and saturate stages, queue write, output register.
// Throughput: one point per cycle while out_stall is low, set by the fully pipelined
// 12-multiplier front end.
// Stalls: in_stall rises while QUEUE_DEPTH points are accepted and not yet popped.
// Reset: synchronous active-low rst_n; matrix to identity, tolerance to 66, queue empty.
module vertex_transform_clip_test_unit import vtc_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // point channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  in_point_x,
  input  logic signed [COORD_W-1:0]  in_point_y,
  input  logic signed [COORD_W-1:0]  in_point_z,
  input  logic                       in_last_point,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_W-1:0]  out_clip_x,
  output logic signed [COORD_W-1:0]  out_clip_y,
  output logic signed [COORD_W-1:0]  out_clip_z,
  output logic signed [COORD_W-1:0]  out_clip_w,
  output logic                       out_overflowed,
  output logic                       out_point_inside,
  output logic                       out_run_done,
  output logic                       out_run_all_inside,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [5:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  logic [MAT_DIM-1:0][ROW_W-1:0] matrix_r;
  logic [TOL_W-1:0]              tol_r;
  logic [REG_IDX_W-1:0]          reg_idx;
  logic                          wr_en;

  logic       q_push, q_pop;
  vtc_entry_t q_entry;
  vtc_qstat_t qstat;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAT_DIM; r++) begin
        matrix_r[r] <= ROW_W'(4096) << (COEF_W * r);
      end
      tol_r <= TOL_W'(66);
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROW0: matrix_r[0] <= pwdata;
        REG_ROW1: matrix_r[1] <= pwdata;
        REG_ROW2: matrix_r[2] <= pwdata;
        REG_ROW3: matrix_r[3] <= pwdata;
        REG_TOL:  tol_r       <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_ROW0: prdata = matrix_r[0];
      REG_ROW1: prdata = matrix_r[1];
      REG_ROW2: prdata = matrix_r[2];
      REG_ROW3: prdata = matrix_r[3];
      REG_TOL:  prdata = {{(64-TOL_W){1'b0}}, tol_r};
      default:  prdata = '0;
    endcase
  end

  // front end
  vtc_xform #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_xform (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .in_last_point (in_last_point),
    .matrix        (matrix_r),
    .q_pop         (q_pop),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  // decoupling queue
  vtc_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .stat       (qstat)
  );

  // back end
  vtc_clip u_clip (
    .clk                (clk),
    .rst_n              (rst_n),
    .tolerance          (tol_r),
    .qstat              (qstat),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_clip_x         (out_clip_x),
    .out_clip_y         (out_clip_y),
    .out_clip_z         (out_clip_z),
    .out_clip_w         (out_clip_w),
    .out_overflowed     (out_overflowed),
    .out_point_inside   (out_point_inside),
    .out_run_done       (out_run_done),
    .out_run_all_inside (out_run_all_inside)
  );

endmodule
